[sv/csem_pkg.sv]
// shared types and codes for the counting semaphore with timed wait
package csem_pkg;

  localparam logic [1:0] FUNC_WAIT   = 2'd0;
  localparam logic [1:0] FUNC_SIGNAL = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [1:0] KIND_GRANT    = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd1;
  localparam logic [1:0] KIND_SIGDONE  = 2'd2;
  localparam logic [1:0] KIND_REJECT   = 2'd3;

  localparam int CNT_W = 16;
  localparam int REL_W = 8;
  localparam int TO_W  = 16;

  // count register value after reset
  localparam logic signed [15:0] INIT_COUNT_RST = 16'sd1;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]       func;
    logic [15:0]      id;
    logic [TO_W-1:0]  timeout;
    logic [REL_W-1:0] rel;
  } cmd_t;

endpackage

[sv/counting_semaphore_timed_wait.sv]
// top level: counting semaphore with fifo of timed waiters
// one command per start beat while busy is low; a wait is decided in the
// idle state, a signal takes one release step per released waiter and a
// done step, a tick one step per queued waiter, all set by the back-end sequencer that walks the waiter
// queue one entry per cycle. results appear on out_* for one cycle each
// marked by out_strobe and cannot be held off; out_last flags the final
// result of a command. a cfg write loads the count and empties the queue;
// busy is high for the cycle after the write while the clear takes place.
module counting_semaphore_timed_wait #(
  parameter int MAX_WAITERS = 16,
  parameter int ID_BITS     = 8,
  parameter int TIMER_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_thread_id,
  input  logic [15:0]        in_timeout,
  input  logic signed [7:0]  in_release_count,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata,
  output logic               out_strobe,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_thread_id_out,
  output logic signed [7:0]  out_released,
  output logic               out_last
);
  logic signed [15:0] init_r;
  logic               full, q_valid, q_pop, busy_bk, clr;
  csem_pkg::cmd_t     q_cmd;

  // config register, reset value one
  always_ff @(posedge clk) begin
    if (!rst_n) init_r <= csem_pkg::INIT_COUNT_RST;
    else if (cfg_we) init_r <= cfg_wdata;
  end
  // clear pulse registered from the write, in the cycle after it, using the new value
  always_ff @(posedge clk) begin
    if (!rst_n) clr <= 1'b0;
    else clr <= cfg_we;
  end

  // one command in flight: front queue holds it until back end is idle
  // no beat is taken while the clear pulse is high
  assign busy = full || busy_bk || q_pop || clr;

  csem_front #(.ID_BITS(ID_BITS)) u_front (
    .clk, .rst_n, .clr,
    .in_valid(start && !busy),
    .in_func, .in_thread_id, .in_timeout,
    .in_release_count(in_release_count),
    .full, .q_valid, .q_cmd, .q_pop
  );

  csem_back #(.MAX_WAITERS(MAX_WAITERS), .ID_BITS(ID_BITS),
              .TIMER_BITS(TIMER_BITS)) u_back (
    .clk, .rst_n, .clr, .init_cnt(init_r),
    .q_valid, .q_cmd, .q_pop, .busy_bk,
    .out_strobe, .out_kind, .out_thread_id_out, .out_released, .out_last
  );
endmodule

[sv/csem_front.sv]
// command front end: accepts beats and queues them for the back end
module csem_front #(
  parameter int ID_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 in_valid,
  input  logic [1:0]           in_func,
  input  logic [7:0]           in_thread_id,
  input  logic [15:0]          in_timeout,
  input  logic [7:0]           in_release_count,
  output logic                 full,
  output logic                 q_valid,
  output csem_pkg::cmd_t       q_cmd,
  input  logic                 q_pop
);
  // two-entry queue
  csem_pkg::cmd_t   mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  csem_pkg::cmd_t   c;
  logic             push;

  always_comb begin
    c         = '0;
    c.func    = in_func;
    c.id      = 16'(in_thread_id[(ID_BITS < 8 ? ID_BITS : 8)-1:0]);
    c.timeout = in_timeout;
    c.rel     = in_release_count;
  end

  // undefined function codes are dropped here
  assign push    = in_valid && (in_func != csem_pkg::FUNC_RSVD) && !clr;
  assign full    = cnt_r != 2'd0;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

[sv/csem_back.sv]
// execution back end: count, waiter queue and result sequencing
module csem_back #(
  parameter int MAX_WAITERS = 16,
  parameter int ID_BITS     = 8,
  parameter int TIMER_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic signed [15:0]   init_cnt,
  input  logic                 q_valid,
  input  csem_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  output logic                 busy_bk,
  output logic                 out_strobe,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_thread_id_out,
  output logic signed [7:0]    out_released,
  output logic                 out_last
);
  localparam int QW = $clog2(MAX_WAITERS + 1);
  localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_REL = 3'd1, S_DONE = 3'd2, S_TICK = 3'd3;

  logic [ID_BITS-1:0]    ids_r  [MAX_WAITERS];
  logic [TIMER_BITS-1:0] tmr_r  [MAX_WAITERS];
  logic [QW-1:0]         tot_r;
  logic signed [16:0]    cnt_r;
  logic [2:0]            st_r;
  logic [7:0]            k_r;
  logic signed [7:0]     rel_r;
  logic [IW:0]           i_r;
  logic                  pend_r;
  logic [ID_BITS-1:0]    pend_id_r;

  logic signed [17:0] sum;
  logic signed [15:0] sat;
  logic [TIMER_BITS-1:0] to_sat, tdec;
  logic [7:0] kk;

  // saturate an 18-bit sum to the signed 16-bit count range
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    if (TIMER_BITS < 16 && (q_cmd.timeout >> TIMER_BITS) != 0) to_sat = '1;
    else to_sat = TIMER_BITS'(q_cmd.timeout);
    kk = (q_cmd.rel > 8'(tot_r)) ? 8'(tot_r) : q_cmd.rel;
    tdec = tmr_r[i_r[IW-1:0]] - 1'b1;
    sum = 18'(cnt_r);
  end

  assign busy_bk = st_r != S_IDLE;
  assign q_pop   = q_valid && st_r == S_IDLE && !clr;

  always_ff @(posedge clk) begin
    out_strobe <= 1'b0;
    if (!rst_n || clr) begin
      st_r  <= S_IDLE;
      tot_r <= '0;
      cnt_r <= rst_n ? 17'(init_cnt) : 17'(csem_pkg::INIT_COUNT_RST);
      out_last <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_pop) begin
          out_kind <= csem_pkg::KIND_GRANT;
          out_thread_id_out <= 8'(q_cmd.id[ID_BITS-1:0]);
          out_released <= '0;
          out_last <= 1'b1;
          unique case (q_cmd.func)
            csem_pkg::FUNC_WAIT: begin
              if (cnt_r > 0) begin
                cnt_r <= cnt_r - 17'sd1;
                out_strobe <= 1'b1;
              end else if (tot_r >= QW'(MAX_WAITERS)) begin
                out_kind <= csem_pkg::KIND_REJECT;
                out_strobe <= 1'b1;
              end else begin
                cnt_r <= 17'(sat16(18'(cnt_r) - 18'sd1));
                ids_r[tot_r[IW-1:0]] <= q_cmd.id[ID_BITS-1:0];
                tmr_r[tot_r[IW-1:0]] <= to_sat;
                tot_r <= tot_r + 1'b1;
              end
            end
            csem_pkg::FUNC_SIGNAL: begin
              if (q_cmd.rel == 0) begin
                cnt_r <= 17'(sat16(18'(cnt_r) + 18'sd1));
                k_r   <= (cnt_r < 0 && tot_r != 0) ? 8'd1 : 8'd0;
                rel_r <= '0;
                st_r  <= (cnt_r < 0 && tot_r != 0) ? S_REL : S_DONE;
              end else if (!q_cmd.rel[7]) begin
                cnt_r <= 17'(sat16(18'(cnt_r) + 18'(q_cmd.rel)));
                k_r   <= kk;
                rel_r <= kk;
                st_r  <= (kk != 0) ? S_REL : S_DONE;
              end else begin
                rel_r <= q_cmd.rel;
                st_r  <= S_DONE;
              end
            end
            default: begin
              i_r    <= '0;
              pend_r <= 1'b0;
              st_r   <= S_TICK;
            end
          endcase
        end
        S_REL: begin
          // grant the head, shift queue up one entry
          out_kind <= csem_pkg::KIND_GRANT;
          out_thread_id_out <= 8'(ids_r[0]);
          out_released <= '0;
          out_last <= 1'b0;
          out_strobe <= 1'b1;
          for (int j = 0; j < MAX_WAITERS - 1; j++) begin
            ids_r[j] <= ids_r[j+1];
            tmr_r[j] <= tmr_r[j+1];
          end
          tot_r <= tot_r - 1'b1;
          k_r <= k_r - 1'b1;
          if (k_r == 8'd1) st_r <= S_DONE;
        end
        S_DONE: begin
          out_kind <= csem_pkg::KIND_SIGDONE;
          out_thread_id_out <= '0;
          out_released <= rel_r;
          out_last <= 1'b1;
          out_strobe <= 1'b1;
          st_r <= S_IDLE;
        end
        S_TICK: begin
          // one queue entry per cycle; expired entries removed in place
          // an expired id is held in pend_r until the next expiry or the end
          // of the walk, so the final timeout beat can carry last
          if ((IW+1)'(i_r) >= (IW+1)'(tot_r)) begin
            st_r <= S_IDLE;
            if (pend_r) begin
              out_kind <= csem_pkg::KIND_TIMEOUT;
              out_thread_id_out <= 8'(pend_id_r);
              out_released <= '0;
              out_last <= 1'b1;
              out_strobe <= 1'b1;
            end
          end else if (tmr_r[i_r[IW-1:0]] != 0 && tdec == 0) begin
            if (pend_r) begin
              out_kind <= csem_pkg::KIND_TIMEOUT;
              out_thread_id_out <= 8'(pend_id_r);
              out_released <= '0;
              out_last <= 1'b0;
              out_strobe <= 1'b1;
            end
            pend_r <= 1'b1;
            pend_id_r <= ids_r[i_r[IW-1:0]];
            cnt_r <= 17'(sat16(sum + 18'sd1));
            for (int j = 0; j < MAX_WAITERS - 1; j++) begin
              if (j >= int'(i_r)) begin
                ids_r[j] <= ids_r[j+1];
                tmr_r[j] <= tmr_r[j+1];
              end
            end
            tot_r <= tot_r - 1'b1;
          end else begin
            if (tmr_r[i_r[IW-1:0]] != 0) tmr_r[i_r[IW-1:0]] <= tdec;
            i_r <= i_r + 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/tb_counting_semaphore_timed_wait.sv]
// self-checking testbench for the counting semaphore with timed wait
module tb_counting_semaphore_timed_wait;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] tid;
    logic signed [7:0] rel;
    logic last;
  } sem_result_t;

  // semaphore scoreboard: own copy of count and waiter queue
  class sem_scoreboard;
    int count;
    logic [7:0] ids[$];
    int timers[$];
    sem_result_t pending[$];
    int errors;

    function void clear(int init);
      count = init;
      ids.delete();
      timers.delete();
    endfunction

    function int sat(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void push(logic [1:0] k, logic [7:0] t, logic signed [7:0] r);
      sem_result_t e;
      e.kind = k;
      e.tid = t;
      e.rel = r;
      e.last = 1'b0;
      pending.push_back(e);
    endfunction

    // note an accepted command beat and queue the results it causes
    function void note_command(logic [1:0] f, logic [7:0] tid, logic [15:0] to,
                               logic signed [7:0] rc);
      int n0, k, i, old;
      n0 = pending.size();
      if (f == csem_pkg::FUNC_WAIT) begin
        if (count - 1 >= 0) begin
          count--;
          push(csem_pkg::KIND_GRANT, tid, 8'sd0);
        end else if (ids.size() >= DEPTH) begin
          push(csem_pkg::KIND_REJECT, tid, 8'sd0);
        end else begin
          count = sat(count - 1);
          ids.push_back(tid);
          timers.push_back(int'(to));
        end
      end else if (f == csem_pkg::FUNC_SIGNAL) begin
        if (rc == 0) begin
          old = count;
          count = sat(count + 1);
          if (old < 0 && ids.size() > 0) begin
            push(csem_pkg::KIND_GRANT, ids.pop_front(), 8'sd0);
            void'(timers.pop_front());
          end
          push(csem_pkg::KIND_SIGDONE, 8'd0, 8'sd0);
        end else if (rc > 0) begin
          count = sat(count + int'(rc));
          k = (int'(rc) > ids.size()) ? ids.size() : int'(rc);
          for (i = 0; i < k; i++) begin
            push(csem_pkg::KIND_GRANT, ids.pop_front(), 8'sd0);
            void'(timers.pop_front());
          end
          push(csem_pkg::KIND_SIGDONE, 8'd0, k[7:0]);
        end else begin
          push(csem_pkg::KIND_SIGDONE, 8'd0, rc);
        end
      end else if (f == csem_pkg::FUNC_TICK) begin
        i = 0;
        while (i < ids.size()) begin
          if (timers[i] != 0) begin
            timers[i]--;
            if (timers[i] == 0) begin
              push(csem_pkg::KIND_TIMEOUT, ids[i], 8'sd0);
              count = sat(count + 1);
              ids.delete(i);
              timers.delete(i);
              continue;
            end
          end
          i++;
        end
      end
      if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [1:0] k, logic [7:0] t, logic signed [7:0] r,
                               logic l);
      sem_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat kind=%0d tid=%0d", k, t);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, k);
        errors++;
      end
      if (t !== e.tid) begin
        $error("thread_id_out: expected %0d actual %0d", e.tid, t);
        errors++;
      end
      if (r !== e.rel) begin
        $error("released: expected %0d actual %0d", e.rel, r);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0d actual %0d", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [7:0] in_thread_id = '0;
  logic [15:0] in_timeout = '0;
  logic signed [7:0] in_release_count = '0;
  logic cfg_we = 1'b0;
  logic signed [15:0] cfg_wdata = '0;
  logic out_strobe;
  logic [1:0] out_kind;
  logic [7:0] out_thread_id_out;
  logic signed [7:0] out_released;
  logic out_last;

  sem_scoreboard sb = new();
  int idle_cycles;

  always #5 clk = ~clk;

  counting_semaphore_timed_wait dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_thread_id(in_thread_id), .in_timeout(in_timeout),
    .in_release_count(in_release_count), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_kind(out_kind),
    .out_thread_id_out(out_thread_id_out), .out_released(out_released),
    .out_last(out_last)
  );

  // result side: every strobe is a beat, compare against oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result(out_kind, out_thread_id_out, out_released, out_last);
  end

  // watchdog: cycles with no accepted beat on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // drive one command, hold start until the block takes it
  // start stays high into the next command when there is no gap
  task automatic send_cmd(logic [1:0] f, logic [7:0] tid, logic [15:0] to,
                          logic signed [7:0] rc, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_thread_id <= tid;
    in_timeout <= to;
    in_release_count <= rc;
    do @(posedge clk); while (busy);
    // accepted at this edge
    sb.note_command(f, tid, to, rc);
  endtask

  // drain all expected beats, let a no-result command finish, then clear
  task automatic write_initial(logic signed [15:0] v);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.clear(int'(v));
  endtask

  // waits, signals and ticks in random mix with zero, short or random timeouts
  task automatic random_cmd(bit gaps);
    int sel;
    logic [15:0] to;
    logic signed [7:0] rc;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: to = 16'd0;
      1: to = 16'($urandom_range(1, 4));
      2: to = 16'($urandom_range(1, 12));
      default: to = 16'($urandom);
    endcase
    if (sel < 8) rc = 8'($urandom);
    else if (sel < 20) rc = 8'sd0;
    else rc = 8'($urandom_range(1, 6));
    if (sel < 40) send_cmd(csem_pkg::FUNC_WAIT, 8'($urandom), to, rc, gaps);
    else if (sel < 62) send_cmd(csem_pkg::FUNC_SIGNAL, 8'($urandom), to, rc, gaps);
    else if (sel < 97) send_cmd(csem_pkg::FUNC_TICK, 8'($urandom), to, rc, gaps);
    else send_cmd(csem_pkg::FUNC_RSVD, 8'($urandom), to, rc, gaps);
  endtask

  initial begin
    int i, j;
    sb.errors = 0;
    sb.clear(1);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: grant, block, full queue, timeouts, every signal flavor
    send_cmd(csem_pkg::FUNC_WAIT, 8'hff, 16'hffff, 8'sd0, 1'b0);
    for (i = 0; i < 17; i++)
      send_cmd(csem_pkg::FUNC_WAIT, 8'(i), (i < 4) ? 16'(i + 1) : 16'd0, 8'sd0, 1'b0);
    send_cmd(csem_pkg::FUNC_TICK, 8'd0, 16'd0, 8'sd0, 1'b0);
    send_cmd(csem_pkg::FUNC_TICK, 8'd0, 16'd0, 8'sh80, 1'b0);
    send_cmd(csem_pkg::FUNC_SIGNAL, 8'd0, 16'd0, 8'sd0, 1'b0);
    send_cmd(csem_pkg::FUNC_SIGNAL, 8'd0, 16'd0, 8'sd3, 1'b0);
    send_cmd(csem_pkg::FUNC_SIGNAL, 8'd0, 16'd0, 8'sh80, 1'b0);
    send_cmd(csem_pkg::FUNC_RSVD, 8'd1, 16'd1, 8'sd1, 1'b0);
    send_cmd(csem_pkg::FUNC_SIGNAL, 8'd0, 16'd0, 8'sd127, 1'b0);

    // saturation extremes of the count
    write_initial(16'sh7fff);
    send_cmd(csem_pkg::FUNC_SIGNAL, 8'd0, 16'd0, 8'sd127, 1'b0);
    send_cmd(csem_pkg::FUNC_WAIT, 8'h5a, 16'd0, 8'sd0, 1'b0);
    write_initial(16'sh8000);
    send_cmd(csem_pkg::FUNC_WAIT, 8'ha5, 16'd1, 8'sd0, 1'b0);
    send_cmd(csem_pkg::FUNC_TICK, 8'd0, 16'd0, 8'sd0, 1'b0);

    // random phases across several initial counts
    for (j = 0; j < 6; j++) begin
      case (j)
        0: write_initial(16'sd0);
        1: write_initial(16'sd2);
        2: write_initial(-16'sd3);
        3: write_initial(16'sd1);
        4: write_initial(16'($urandom_range(0, 8)));
        default: write_initial(16'sh8000);
      endcase
      for (i = 0; i < 80; i++) random_cmd((j % 3) != 1);
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
